[rtl/core/sia_pkg.sv]
package sia_pkg;

  localparam int DataWidthDef = 32;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_MOD = 4'd4,
    OP_EQ  = 4'd5,
    OP_NE  = 4'd6,
    OP_GT  = 4'd7,
    OP_GE  = 4'd8,
    OP_LT  = 4'd9,
    OP_LE  = 4'd10
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DIVZERO = 2'd1,
    ST_BADOP   = 2'd2
  } status_t;

  // Per-stage control that travels alongside the datapath
  typedef struct packed {
    logic    valid;
    logic    is_div;
    logic    is_mod;
    logic    neg_q;
    logic    neg_r;
    logic    is_boolean;
    status_t status;
  } ctl_t;

endpackage

[rtl/core/sia_div_stage.sv]
// One restoring-division step per stage: shift in one dividend bit, trial subtract.
module sia_div_stage #(
  parameter int DATA_WIDTH = sia_pkg::DataWidthDef
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  in_valid,
  input  logic [DATA_WIDTH-1:0] rem_in,
  input  logic [DATA_WIDTH-1:0] quo_in,
  input  logic [DATA_WIDTH-1:0] dvs_in,
  output logic                  out_valid,
  output logic [DATA_WIDTH-1:0] rem_out,
  output logic [DATA_WIDTH-1:0] quo_out,
  output logic [DATA_WIDTH-1:0] dvs_out
);
  import sia_pkg::*;

  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH:0]   diff;
  logic [DATA_WIDTH-1:0] rem_nxt;
  logic [DATA_WIDTH-1:0] quo_nxt;
  logic                  valid_r;
  logic [DATA_WIDTH-1:0] rem_r;
  logic [DATA_WIDTH-1:0] quo_r;
  logic [DATA_WIDTH-1:0] dvs_r;

  // trial subtract of divisor from shifted partial remainder
  always_comb begin
    trial = {rem_in, quo_in[DATA_WIDTH-1]};
    diff  = trial - {1'b0, dvs_in};
    if (!diff[DATA_WIDTH]) begin
      rem_nxt = diff[DATA_WIDTH-1:0];
      quo_nxt = {quo_in[DATA_WIDTH-2:0], 1'b1};
    end else begin
      rem_nxt = trial[DATA_WIDTH-1:0];
      quo_nxt = {quo_in[DATA_WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      dvs_r <= dvs_in;
    end
  end

  assign out_valid = valid_r;
  assign rem_out   = rem_r;
  assign quo_out   = quo_r;
  assign dvs_out   = dvs_r;

endmodule

[rtl/core/signed_int_alu_32.sv]
// Signed integer ALU, fully pipelined: one transaction accepted per cycle while
// in_stall is low. A transaction passes DATA_WIDTH + 1 register stages:
// DATA_WIDTH restoring-divide steps, the first of which also registers the
// decoded operation, then the sign fix into the output register. The divider
// chain sets the depth; multiply and compares ride alongside. in_stall follows
// out_stall while the output register holds an untaken result.
module signed_int_alu_32 #(
  parameter int DATA_WIDTH = sia_pkg::DataWidthDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [3:0]                   in_opcode,
  input  logic signed [DATA_WIDTH-1:0] in_left_operand,
  input  logic signed [DATA_WIDTH-1:0] in_right_operand,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_result_value,
  output logic                         out_is_boolean,
  output logic [1:0]                   out_status
);
  import sia_pkg::*;

  localparam int N = DATA_WIDTH;

  logic adv;
  logic [N-1:0] a;
  logic [N-1:0] b;
  logic an;
  logic bn;
  logic [N-1:0] res_nxt;
  ctl_t ctl_nxt;
  logic [N-1:0] ma;
  logic [N-1:0] mb;

  ctl_t         ctl_r [N];
  logic [N-1:0] fast_r [N];
  logic [N-1:0] ma_r;
  logic [N-1:0] mb_r;
  logic         mul_r;

  logic         dv_valid [N+1];
  logic [N-1:0] dv_rem [N+1];
  logic [N-1:0] dv_quo [N+1];
  logic [N-1:0] dv_dvs [N+1];

  logic [N-1:0] fix_nxt;
  logic         out_valid_r;
  logic [N-1:0] res_r;
  logic         isb_r;
  status_t      st_r;

  // whole pipe advances unless the output holds an untaken result
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  assign a  = in_left_operand;
  assign b  = in_right_operand;
  assign an = a[N-1];
  assign bn = b[N-1];
  assign ma = an ? (~a + 1'b1) : a;
  assign mb = bn ? (~b + 1'b1) : b;

  // decode: compares, add/sub, status; multiply uses a following stage
  always_comb begin
    res_nxt = '0;
    ctl_nxt = '0;
    ctl_nxt.valid  = in_valid;
    ctl_nxt.status = ST_OK;
    unique case (in_opcode)
      OP_ADD: res_nxt = a + b;
      OP_SUB: res_nxt = a - b;
      OP_MUL: res_nxt = '0;
      OP_DIV, OP_MOD: begin
        if (b == '0) begin
          ctl_nxt.status = ST_DIVZERO;
        end else begin
          ctl_nxt.is_div = (in_opcode == OP_DIV);
          ctl_nxt.is_mod = (in_opcode == OP_MOD);
          ctl_nxt.neg_q  = an ^ bn;
          ctl_nxt.neg_r  = an;
        end
      end
      OP_EQ: begin res_nxt = N'(a == b); ctl_nxt.is_boolean = 1'b1; end
      OP_NE: begin res_nxt = N'(a != b); ctl_nxt.is_boolean = 1'b1; end
      OP_GT: begin res_nxt = N'($signed(a) >  $signed(b)); ctl_nxt.is_boolean = 1'b1; end
      OP_GE: begin res_nxt = N'($signed(a) >= $signed(b)); ctl_nxt.is_boolean = 1'b1; end
      OP_LT: begin res_nxt = N'($signed(a) <  $signed(b)); ctl_nxt.is_boolean = 1'b1; end
      OP_LE: begin res_nxt = N'($signed(a) <= $signed(b)); ctl_nxt.is_boolean = 1'b1; end
      default: ctl_nxt.status = ST_BADOP;
    endcase
  end

  // stage 0: decode register; product selected into fast path at stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0].valid <= 1'b0;
    end else if (adv) begin
      ctl_r[0] <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fast_r[0] <= res_nxt;
      ma_r      <= a;
      mb_r      <= b;
      mul_r     <= (in_opcode == OP_MUL);
    end
  end

  // divider entry: magnitudes, registered alongside decode
  assign dv_valid[0] = in_valid;
  assign dv_rem[0]   = '0;
  assign dv_quo[0]   = ma;
  assign dv_dvs[0]   = (mb == '0) ? {{(N-1){1'b0}}, 1'b1} : mb;

  for (genvar i = 0; i < N; i++) begin : g_div
    sia_div_stage #(.DATA_WIDTH(N)) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (dv_valid[i]),
      .rem_in    (dv_rem[i]),
      .quo_in    (dv_quo[i]),
      .dvs_in    (dv_dvs[i]),
      .out_valid (dv_valid[i+1]),
      .rem_out   (dv_rem[i+1]),
      .quo_out   (dv_quo[i+1]),
      .dvs_out   (dv_dvs[i+1])
    );
  end

  // control and fast results delayed to match the divider chain
  for (genvar s = 1; s < N; s++) begin : g_dly
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[s].valid <= 1'b0;
      end else if (adv) begin
        ctl_r[s] <= ctl_r[s-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if (s == 1) begin
          fast_r[s] <= mul_r ? (ma_r * mb_r) : fast_r[s-1];
        end else begin
          fast_r[s] <= fast_r[s-1];
        end
      end
    end
  end

  // sign fix of divider result, aligned with ctl_r[N-1]
  always_comb begin
    fix_nxt = fast_r[N-1];
    if (ctl_r[N-1].is_div) begin
      fix_nxt = ctl_r[N-1].neg_q ? (~dv_quo[N] + 1'b1) : dv_quo[N];
    end else if (ctl_r[N-1].is_mod) begin
      fix_nxt = ctl_r[N-1].neg_r ? (~dv_rem[N] + 1'b1) : dv_rem[N];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ctl_r[N-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= fix_nxt;
      isb_r <= ctl_r[N-1].is_boolean;
      st_r  <= ctl_r[N-1].status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = res_r;
  assign out_is_boolean   = isb_r;
  assign out_status       = st_r;

`ifndef SYNTH
  // divider valid tracks the control pipe
  a_div_align: assert property (@(posedge clk) disable iff (!rst_n)
    dv_valid[N] == ctl_r[N-1].valid)
    else $error("divider out of step with control");
  // stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_value))
    else $error("output changed under stall");
  // booleans are 0 or 1 with ok status
  a_bool: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_boolean |-> out_result_value[N-1:1] == '0 && out_status == ST_OK)
    else $error("bad boolean result");
  // error results are zero and not boolean
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_result_value == '0 && !out_is_boolean)
    else $error("error result not zero");
`endif

endmodule
